// ===== rtl/core/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Field widths, opcodes, command format passed from front to back.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Field widths fixed by the transaction format
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int DATA_W = 32;

  // Largest screen is 128 x 32 cells
  localparam int ADDR_W = 12;

  // Default screen geometry
  localparam int DEF_WIDTH  = 80;
  localparam int DEF_HEIGHT = 25;

  // Command queue depth (power of two)
  localparam int QDEPTH = 2;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] NL_CODE        = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'd32;
  localparam logic [CHAR_W-1:0] TEXT_COLOR_RST = 8'd7;
  localparam logic [CELL_W-1:0] INIT_CELL      = {TEXT_COLOR_RST, SPACE_CODE};

  // Input opcodes
  typedef enum logic [1:0] {
    OP_PUT_CHAR = 2'd0,
    OP_PUT_CELL = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // Memory action for the back end
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_kind_t;

  // One classified command
  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [CELL_W-1:0]  wdata;
    logic               row_clear;
    logic [ADDR_W-1:0]  row_base;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic               scrolled;
    logic               ignored;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front: input decode and cursor tracking
// Accepts transactions, tracks cursor and scroll offset, and turns each
// transaction into one memory command with its result fields.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int WIDTH  = tcw_pkg::DEF_WIDTH,
  parameter int HEIGHT = tcw_pkg::DEF_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [tcw_pkg::DATA_W-1:0]  s_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  cfg_wdata,
  input  wire logic                        q_full,
  input  wire logic                        init_busy,
  output logic                             q_push,
  output tcw_pkg::cmd_t                    q_cmd
);

  localparam logic [tcw_pkg::COL_W:0]    WIDTH_C  = (tcw_pkg::COL_W+1)'(WIDTH);
  localparam logic [tcw_pkg::ROW_W:0]    HEIGHT_R = (tcw_pkg::ROW_W+1)'(HEIGHT);
  localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST = tcw_pkg::ROW_W'(HEIGHT - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] WIDTH_A  = tcw_pkg::ADDR_W'(WIDTH);

  // Architectural state
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::ROW_W-1:0]  top;
  logic [tcw_pkg::CHAR_W-1:0] text_color;
  logic [tcw_pkg::COL_W-1:0]  cursor_col_next;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row_next;
  logic [tcw_pkg::ROW_W-1:0]  top_next;

  // Payload fields
  tcw_pkg::op_t                op;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::CHAR_W-1:0]  cell_color;
  logic [tcw_pkg::COL_W-1:0]   col;
  logic [tcw_pkg::ROW_W-1:0]   row;

  assign op         = tcw_pkg::op_t'(s_tdata[1:0]);
  assign char_code  = s_tdata[9:2];
  assign cell_color = s_tdata[17:10];
  assign col        = s_tdata[24:18];
  assign row        = s_tdata[29:25];

  // Logical row to physical row, offset by the scroll pointer
  function automatic logic [tcw_pkg::ROW_W-1:0] phys_row(
    input logic [tcw_pkg::ROW_W-1:0] r,
    input logic [tcw_pkg::ROW_W-1:0] t
  );
    logic [tcw_pkg::ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (sum >= HEIGHT_R) begin
      sum = sum - HEIGHT_R;
    end
    return sum[tcw_pkg::ROW_W-1:0];
  endfunction

  function automatic logic [tcw_pkg::ADDR_W-1:0] row_base(
    input logic [tcw_pkg::ROW_W-1:0] pr
  );
    return tcw_pkg::ADDR_W'(pr) * WIDTH_A;
  endfunction

  assign s_tready = !q_full && !init_busy;
  assign q_push   = s_tvalid && s_tready;

  // Classify the transaction and work out the next cursor
  always_comb begin
    logic                       in_range;
    logic                       nl;
    logic [tcw_pkg::COL_W:0]    col_inc;
    logic                       wrap;
    in_range = ({1'b0, col} < WIDTH_C) && ({1'b0, row} < HEIGHT_R);
    nl       = (char_code == tcw_pkg::NL_CODE);
    col_inc  = {1'b0, cursor_col} + 1'b1;
    wrap     = nl || (col_inc == WIDTH_C);

    q_cmd           = '0;
    q_cmd.kind      = tcw_pkg::CMD_NONE;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    top_next        = top;

    case (op)
      tcw_pkg::OP_PUT_CHAR: begin
        if (!nl) begin
          q_cmd.kind      = tcw_pkg::CMD_WRITE;
          q_cmd.addr      = row_base(phys_row(cursor_row, top)) +
                            tcw_pkg::ADDR_W'(cursor_col);
          q_cmd.wdata     = {text_color, char_code};
          cursor_col_next = col_inc[tcw_pkg::COL_W-1:0];
        end
        if (wrap) begin
          cursor_col_next = '0;
          if (cursor_row == ROW_LAST) begin
            // old top row becomes the new, blank bottom row
            q_cmd.row_clear = 1'b1;
            q_cmd.row_base  = row_base(top);
            q_cmd.scrolled  = 1'b1;
            top_next        = (top == ROW_LAST) ? '0 : top + 1'b1;
          end else begin
            cursor_row_next = cursor_row + 1'b1;
          end
        end
      end
      tcw_pkg::OP_PUT_CELL: begin
        if (in_range) begin
          q_cmd.kind  = tcw_pkg::CMD_WRITE;
          q_cmd.addr  = row_base(phys_row(row, top)) + tcw_pkg::ADDR_W'(col);
          q_cmd.wdata = {cell_color, char_code};
        end else begin
          q_cmd.ignored = 1'b1;
        end
      end
      tcw_pkg::OP_READ: begin
        if (in_range) begin
          q_cmd.kind = tcw_pkg::CMD_READ;
          q_cmd.addr = row_base(phys_row(row, top)) + tcw_pkg::ADDR_W'(col);
        end else begin
          q_cmd.ignored = 1'b1;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        q_cmd.kind      = tcw_pkg::CMD_FILL;
        q_cmd.wdata     = {text_color, tcw_pkg::SPACE_CODE};
        cursor_col_next = '0;
        cursor_row_next = '0;
      end
      default: begin
        q_cmd.kind = tcw_pkg::CMD_NONE;
      end
    endcase

    q_cmd.cursor_col = cursor_col_next;
    q_cmd.cursor_row = cursor_row_next;
  end

  // Cursor, scroll pointer and color register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      top        <= '0;
      text_color <= tcw_pkg::TEXT_COLOR_RST;
    end else begin
      if (q_push) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        top        <= top_next;
      end
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_queue: command queue between front and back
// Small register FIFO so the two sides stall independently.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tcw_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output tcw_pkg::cmd_t       head_cmd,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = $clog2(tcw_pkg::QDEPTH);
  localparam int CNT_W = $clog2(tcw_pkg::QDEPTH + 1);

  tcw_pkg::cmd_t      slots [tcw_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(tcw_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign head_cmd = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back: screen memory and command execution
// Owns the cell memory, runs the reset, row-clear and screen-fill sweeps,
// and holds the result register toward the output stream.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int WIDTH  = tcw_pkg::DEF_WIDTH,
  parameter int HEIGHT = tcw_pkg::DEF_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tcw_pkg::cmd_t               head_cmd,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic                             init_busy,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [tcw_pkg::DATA_W-1:0]       m_tdata
);

  localparam int CELLS = WIDTH * HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(WIDTH - 1);

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t                       state;
  logic [tcw_pkg::CELL_W-1:0]   mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]   rdata;
  logic [AW-1:0]                sweep_addr;
  logic [AW-1:0]                sweep_last;
  logic [tcw_pkg::CELL_W-1:0]   sweep_data;
  tcw_pkg::cmd_t                pend;
  logic                         pend_read;

  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
  logic                         mem_re;
  logic                         sweeping;

  assign init_busy = (state == ST_INIT);
  assign sweeping  = (state == ST_INIT) || (state == ST_SWEEP);
  assign q_pop     = (state == ST_IDLE) && !q_empty;

  // Memory port select: sweeps own the port, otherwise the popped command
  always_comb begin
    mem_we    = sweeping || (q_pop && (head_cmd.kind == tcw_pkg::CMD_WRITE));
    mem_re    = q_pop && (head_cmd.kind == tcw_pkg::CMD_READ);
    mem_addr  = sweeping ? sweep_addr : head_cmd.addr[AW-1:0];
    mem_wdata = head_cmd.wdata;
    if (state == ST_INIT) begin
      mem_wdata = tcw_pkg::INIT_CELL;
    end else if (state == ST_SWEEP) begin
      mem_wdata = sweep_data;
    end
  end

  // Cell memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // Pending command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend      <= head_cmd;
      pend_read <= (head_cmd.kind == tcw_pkg::CMD_READ);
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep_addr <= '0;
      sweep_last <= LAST_CELL;
      sweep_data <= tcw_pkg::INIT_CELL;
      m_tvalid   <= 1'b0;
    end else begin
      // result taken; in ST_RESP the load below decides instead
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_CELL) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            if (head_cmd.kind == tcw_pkg::CMD_FILL) begin
              sweep_addr <= '0;
              sweep_last <= LAST_CELL;
              sweep_data <= head_cmd.wdata;
              state      <= ST_SWEEP;
            end else if (head_cmd.row_clear) begin
              sweep_addr <= head_cmd.row_base[AW-1:0];
              sweep_last <= head_cmd.row_base[AW-1:0] + ROW_SPAN;
              sweep_data <= '0;
              state      <= ST_SWEEP;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_last) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, pend.ignored, pend.scrolled,
                         pend.cursor_row, pend.cursor_col,
                         pend_read ? rdata : {tcw_pkg::CELL_W{1'b0}}};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with scrolling
// Character cell screen with cursor, wrap, newline and scroll, plus direct
// cell put/read and clear screen.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  op, char_code, cell_color, col, row
//   m_*      out  m_tvalid/m_tready  cell_char, cell_attr, cursor_col,
//                                    cursor_row, scrolled, ignored
//   cfg_*    in   cfg_we             text_color
//
// In the back end an ordinary transaction goes through a memory access, then
// the result register. A scroll also blanks the new bottom row (rows rotate
// through a top-row pointer); clear screen adds a fill of every cell. After
// reset the memory is filled with blank cells while s_tready is low. The
// two-entry command queue keeps accepting while the back end sweeps or the
// output stalls, until it fills.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int WIDTH  = tcw_pkg::DEF_WIDTH,
  parameter int HEIGHT = tcw_pkg::DEF_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // [1:0] op, [9:2] char_code, [17:10] cell_color, [24:18] col, [29:25] row
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [tcw_pkg::DATA_W-1:0]  s_tdata,
  // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col,
  // [27:23] cursor_row, [28] scrolled, [29] ignored
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [tcw_pkg::DATA_W-1:0]       m_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  cfg_wdata
);

  tcw_pkg::cmd_t push_cmd;
  tcw_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic          init_busy;

  // Decode and cursor tracking
  tcw_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue
  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Screen memory and execution
  tcw_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tcw_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the stream ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int WIDTH  = tcw_pkg::DEF_WIDTH,
  parameter int HEIGHT = tcw_pkg::DEF_HEIGHT
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [tcw_pkg::DATA_W-1:0]  m_tdata
);

  // Memory fill after reset blocks input
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during reset fill");

  // A stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // Reported cursor lies on the screen
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[22:16] < WIDTH) && (m_tdata[27:23] < HEIGHT))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |->
      (m_tdata[27:23] == (HEIGHT - 1)) && (m_tdata[22:16] == 0))
    else $error("scroll with cursor not at bottom row start");

  // A dropped access returns no data and does not scroll
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29] |-> (m_tdata[15:0] == 0) && !m_tdata[28])
    else $error("ignored access carries data or scroll");

endmodule

bind text_console_writer tcw_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/text_console_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Drives console commands on the input stream and predicts every status
// transaction from a local screen image, cursor and text color. Directed tests
// cover reset contents, range checks, newline and clear. Random traffic then
// covers text lines, wraps, scrolls, clears and cell accesses under varied stalls.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int WIDTH  = DEF_WIDTH;
  localparam int HEIGHT = DEF_HEIGHT;
  // Full-screen fill plus a few row blanks, cycles
  localparam int SWEEP_PAUSE  = WIDTH * HEIGHT + 4 * WIDTH + 64;
  localparam int DRAIN_PAUSE  = 4 * WIDTH + 64;
  localparam int STALL_LIMIT  = 8 * WIDTH * HEIGHT;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_PRINTED  = 40;

  // Input transaction, last field in the low bits
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] clr;
    logic [CHAR_W-1:0] chr;
    op_t               op;
  } console_cmd_t;

  // Status transaction, last field in the low bits
  typedef struct packed {
    logic              ignored;
    logic              scrolled;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
  } console_status_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;  // [1:0] op, [9:2] char_code, [17:10] cell_color,
                                      // [24:18] col, [29:25] row
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // [7:0] cell_char, [15:8] cell_attr,
                                      // [22:16] cursor_col, [27:23] cursor_row,
                                      // [28] scrolled, [29] ignored
  logic              cfg_we    = 1'b0;
  logic [CHAR_W-1:0] cfg_wdata = '0;

  // Screen image and cursor as the block should hold them
  logic [CELL_W-1:0] screen_model [HEIGHT][WIDTH];
  int                cur_col;
  int                cur_row;
  logic [CHAR_W-1:0] color_model;

  console_status_t   expected_status [$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int idle_cycles     = 0;
  int error_count     = 0;
  int cmds_sent       = 0;
  int results_seen    = 0;
  int scroll_count    = 0;
  int wrap_count      = 0;
  int clear_count     = 0;
  int read_count      = 0;
  int dropped_count   = 0;
  int color_writes    = 0;

  always #1 clk = ~clk;

  text_console_writer #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_console_model();
    int x, y;
    for (y = 0; y < HEIGHT; y++)
      for (x = 0; x < WIDTH; x++)
        screen_model[y][x] = INIT_CELL;
    cur_col     = 0;
    cur_row     = 0;
    color_model = TEXT_COLOR_RST;
  endfunction

  function automatic console_status_t apply_command(console_cmd_t c);
    console_status_t st;
    logic            in_range;
    int              x, y;
    st       = '0;
    in_range = (c.col < WIDTH) && (c.row < HEIGHT);
    case (c.op)
      OP_PUT_CHAR: begin
        if (c.chr != NL_CODE) begin
          screen_model[cur_row][cur_col] = {color_model, c.chr};
          cur_col++;
          if (cur_col >= WIDTH) begin
            cur_col = 0;
            cur_row++;
            wrap_count++;
          end
        end else begin
          cur_col = 0;
          cur_row++;
        end
        // rows move up, bottom row becomes zero cells
        if (cur_row >= HEIGHT) begin
          for (y = 0; y < HEIGHT - 1; y++)
            for (x = 0; x < WIDTH; x++)
              screen_model[y][x] = screen_model[y + 1][x];
          for (x = 0; x < WIDTH; x++)
            screen_model[HEIGHT - 1][x] = '0;
          cur_row     = HEIGHT - 1;
          st.scrolled = 1'b1;
          scroll_count++;
        end
      end
      OP_PUT_CELL: begin
        if (in_range)
          screen_model[c.row][c.col] = {c.clr, c.chr};
        else
          st.ignored = 1'b1;
      end
      OP_READ: begin
        read_count++;
        if (in_range)
          {st.cell_attr, st.cell_char} = screen_model[c.row][c.col];
        else
          st.ignored = 1'b1;
      end
      default: begin
        for (y = 0; y < HEIGHT; y++)
          for (x = 0; x < WIDTH; x++)
            screen_model[y][x] = {color_model, SPACE_CODE};
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
    endcase
    if (st.ignored)
      dropped_count++;
    st.cursor_col = COL_W'(cur_col);
    st.cursor_row = ROW_W'(cur_row);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] rand_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // mostly on screen, sometimes anywhere the field allows
  function automatic logic [COL_W-1:0] pick_col();
    if ($urandom_range(0, 9) < 8)
      return COL_W'($urandom_range(0, WIDTH - 1));
    return COL_W'($urandom_range(0, 127));
  endfunction

  // bias toward the cursor row so recent text gets read back
  function automatic logic [ROW_W-1:0] pick_row();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return ROW_W'(cur_row);
    if (r < 8)
      return ROW_W'($urandom_range(0, HEIGHT - 1));
    return ROW_W'($urandom_range(0, 31));
  endfunction

  // One input transaction; prediction is made at the accepting edge
  task automatic send_cmd(input op_t op, input logic [CHAR_W-1:0] chr,
                          input logic [CHAR_W-1:0] clr, input logic [COL_W-1:0] col,
                          input logic [ROW_W-1:0] row);
    console_cmd_t c;
    c.op  = op;
    c.chr = chr;
    c.clr = clr;
    c.col = col;
    c.row = row;
    s_tdata  <= {{(DATA_W - $bits(console_cmd_t)){1'b0}}, c};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    expected_status.push_back(apply_command(c));
    cmds_sent++;
    // random source gaps
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] chr);
    send_cmd(OP_PUT_CHAR, chr, rand_byte(), COL_W'($urandom_range(0, 127)),
             ROW_W'($urandom_range(0, 31)));
  endtask

  // Wait for every status transaction, then let background sweeps finish
  task automatic wait_idle(input int pause);
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0)
      @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic set_text_color(input logic [CHAR_W-1:0] value);
    wait_idle(SWEEP_PAUSE);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    color_model  = value;
    color_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_contents();
    send_cmd(OP_READ, rand_byte(), rand_byte(), '0, '0);
    send_cmd(OP_READ, rand_byte(), rand_byte(), COL_W'(WIDTH - 1), ROW_W'(HEIGHT - 1));
  endtask

  task automatic test_cell_access();
    send_cmd(OP_PUT_CELL, 8'hFF, 8'hFF, COL_W'(WIDTH - 1), ROW_W'(HEIGHT - 1));
    send_cmd(OP_READ, 8'h00, 8'h00, COL_W'(WIDTH - 1), ROW_W'(HEIGHT - 1));
    // off the right edge and below the bottom: dropped
    send_cmd(OP_PUT_CELL, 8'h41, 8'h1F, 7'h7F, '0);
    send_cmd(OP_PUT_CELL, 8'h42, 8'h2E, '0, 5'h1F);
    send_cmd(OP_READ, 8'h00, 8'h00, COL_W'(WIDTH), ROW_W'(HEIGHT - 1));
    send_cmd(OP_READ, 8'h00, 8'h00, '0, ROW_W'(HEIGHT));
    send_cmd(OP_PUT_CELL, 8'h00, 8'h00, '0, '0);
  endtask

  task automatic test_put_char();
    put_char(8'hFF);
    put_char(8'h00);
    put_char(NL_CODE);
    send_cmd(OP_READ, rand_byte(), rand_byte(), '0, '0);
    send_cmd(OP_READ, rand_byte(), rand_byte(), 7'd1, '0);
  endtask

  task automatic test_clear_color();
    set_text_color(8'hA5);
    send_cmd(OP_CLEAR, rand_byte(), rand_byte(), COL_W'($urandom_range(0, 127)),
             ROW_W'($urandom_range(0, 31)));
    send_cmd(OP_READ, rand_byte(), rand_byte(), COL_W'(WIDTH - 1), ROW_W'(HEIGHT - 1));
    put_char(8'h5A);
    send_cmd(OP_READ, rand_byte(), rand_byte(), '0, '0);
  endtask

  // Mostly text lines and cell traffic, with long lines, newline runs, clears and noise
  task automatic run_random_phase(input int tx_idle, input int rx_stall, input int count);
    int first, kind;
    sender_idle_pct = tx_idle;
    stall_pct       = rx_stall;
    first           = cmds_sent;
    while (cmds_sent - first < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        repeat ($urandom_range(0, 20)) put_char(rand_byte());
        put_char(NL_CODE);
      end else if (kind < 58) begin
        // long enough to wrap
        repeat ($urandom_range(WIDTH, WIDTH + 12))
          put_char(CHAR_W'($urandom_range(33, 126)));
      end else if (kind < 68) begin
        repeat ($urandom_range(3, HEIGHT)) put_char(NL_CODE);
      end else if (kind < 96) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1))
            send_cmd(OP_READ, rand_byte(), rand_byte(), pick_col(), pick_row());
          else
            send_cmd(OP_PUT_CELL, rand_byte(), rand_byte(), pick_col(), pick_row());
        end
      end else if (kind < 98) begin
        send_cmd(OP_CLEAR, rand_byte(), rand_byte(), COL_W'($urandom_range(0, 127)),
                 ROW_W'($urandom_range(0, 31)));
      end else begin
        // noise: any op, any field
        send_cmd(op_t'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                 COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_text_color(8'h00);
    run_random_phase(0, 0, PHASE_ITEMS);
    set_text_color(8'hFF);
    run_random_phase(51, 0, PHASE_ITEMS);
    set_text_color(CHAR_W'($urandom_range(1, 254)));
    run_random_phase(0, 51, PHASE_ITEMS);
    set_text_color(TEXT_COLOR_RST);
    run_random_phase(20, 20, PHASE_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stalls, checking, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : status_check
    console_status_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = console_status_t'(m_tdata[$bits(console_status_t)-1:0]);
      results_seen++;
      if (expected_status.size() == 0) begin
        report_mismatch($sformatf("status %h with no command outstanding", m_tdata));
      end else begin
        want = expected_status.pop_front();
        if (got.cell_char !== want.cell_char)
          report_mismatch($sformatf("status %0d cell_char %h, want %h",
                                    results_seen, got.cell_char, want.cell_char));
        if (got.cell_attr !== want.cell_attr)
          report_mismatch($sformatf("status %0d cell_attr %h, want %h",
                                    results_seen, got.cell_attr, want.cell_attr));
        if (got.cursor_col !== want.cursor_col)
          report_mismatch($sformatf("status %0d cursor_col %0d, want %0d",
                                    results_seen, got.cursor_col, want.cursor_col));
        if (got.cursor_row !== want.cursor_row)
          report_mismatch($sformatf("status %0d cursor_row %0d, want %0d",
                                    results_seen, got.cursor_row, want.cursor_row));
        if (got.scrolled !== want.scrolled)
          report_mismatch($sformatf("status %0d scrolled %b, want %b",
                                    results_seen, got.scrolled, want.scrolled));
        if (got.ignored !== want.ignored)
          report_mismatch($sformatf("status %0d ignored %b, want %b",
                                    results_seen, got.ignored, want.ignored));
      end
    end
  end

  // no transaction on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d status pending",
               idle_cycles, expected_status.size());
      $display("text_console_writer_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_console_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_cell_access();
    test_put_char();
    test_clear_color();
    test_random_traffic();

    wait_idle(DRAIN_PAUSE);
    $display("Ran %0d commands and checked %0d status transactions over %0d colors",
             cmds_sent, results_seen, color_writes);
    $display("Saw %0d scrolls, %0d wraps, %0d clears, %0d reads, %0d dropped accesses",
             scroll_count, wrap_count, clear_count, read_count, dropped_count);
    if (error_count == 0)
      $display("text_console_writer_tb: PASS");
    else
      $display("text_console_writer_tb: FAIL");
    $finish;
  end

endmodule

// ===== text_console_writer.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_checker.sv
tb/sv/text_console_writer_tb.sv
